// ===== sv/aik_pkg.sv =====
// ----------------------------------------------------------------------------
// aik_pkg: shared types and constants for the arm inverse kinematics core
// Sequencer states, iterative unit opcodes, status codes and angle constants.
// ----------------------------------------------------------------------------
package aik_pkg;

  // result status codes
  localparam logic [1:0] STAT_SOLVED = 2'd0;
  localparam logic [1:0] STAT_FLOOR  = 2'd1;
  localparam logic [1:0] STAT_REACH  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_BASE_HEIGHT = 3'd0;
  localparam logic [2:0] REG_SHOULDER    = 3'd1;
  localparam logic [2:0] REG_ELBOW       = 3'd2;
  localparam logic [2:0] REG_WRIST       = 3'd3;
  localparam logic [2:0] REG_WRIST_MODE  = 3'd4;

  // wrist pitch modes
  localparam logic [2:0] WM_UP90   = 3'd0;
  localparam logic [2:0] WM_UP45   = 3'd1;
  localparam logic [2:0] WM_LEVEL  = 3'd2;
  localparam logic [2:0] WM_DOWN45 = 3'd3;
  localparam logic [2:0] WM_DOWN90 = 3'd4;

  // angles with 30 fraction bits
  localparam logic signed [35:0] PI_W         = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_W    = 36'sd1686629713;
  localparam logic signed [35:0] QUARTER_PI_W = 36'sd843314857;
  localparam logic [16:0]        COS45_Q16    = 17'd46341;
  localparam int                 WORK_FRAC    = 30;
  localparam int                 ATAN_LEN     = 24;

  typedef enum logic [1:0] {
    OP_VEC,
    OP_SQRT,
    OP_DIV
  } aik_op_t;

  typedef struct packed {
    logic    start;
    aik_op_t op;
  } aik_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aik_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MXX,
    ST_MYY,
    ST_MC45,
    ST_PD,
    ST_BASE,
    ST_TXY,
    ST_MTX,
    ST_MTY,
    ST_ML1,
    ST_ML2,
    ST_MRE,
    ST_MRM,
    ST_CHK,
    ST_DIST,
    ST_THETA,
    ST_MDEN,
    ST_ASET,
    ST_ACHK,
    ST_ADIV,
    ST_ASGN,
    ST_AMUL,
    ST_ASQ,
    ST_AVEC,
    ST_FIN,
    ST_DONE
  } aik_state_t;

  // atan(2^-i) with 30 fraction bits
  function automatic logic [30:0] atan_lut(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/arm_inverse_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_core: base yaw plus two-link planar IK solver
// Solves base, shoulder, elbow and wrist angles for a target point with the
// wrist held at a fixed pitch; keeps and re-answers the last good pose.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload
// -------  ---  --------------------------------------------------------------
// in_      in   tdata: target_x[12:0], target_y[25:13], target_z[38:26]
// out_     out  tuser: status; tdata: base, shoulder, elbow, wrist angles
// cfg_     in   cfg_index selects register, cfg_data carries the value
//
// Each target runs four CORDIC passes, four square roots and two divides plus
// the multiply and setup states, all serialized through the one shared
// iterative unit; a clamped cosine skips its divide. A target below the floor
// goes from idle straight to the final state, which loads its result into the
// output register and returns the sequencer to idle. in_tready is high only
// while the sequencer is idle. The result sits in an output register; while
// out_tready stalls, the next finished result waits in the final state and no
// new target is taken. Reset is synchronous; the configuration port is always
// ready.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics_core
  import aik_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // slave stream: target_x, target_y, target_z (low to high), zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // master stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // base_angle, shoulder_angle, elbow_angle, wrist_angle (low to high)
  output logic [63:0] out_tdata,
  // status
  output logic [1:0]  out_tuser,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int                 SH       = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [35:0] HALF_LSB = 36'sd1 <<< (SH - 1);

  // round half up to the output grid, then saturate
  function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + HALF_LSB) >>> SH;
    if (r > 36'sd32767)       return 16'sh7fff;
    else if (r < -36'sd32768) return 16'sh8000;
    else                      return r[15:0];
  endfunction

  // configuration
  logic [11:0] base_height_r, l1_r, l2_r, l3_r;
  logic [2:0]  wrist_mode_r;

  // sequencer
  aik_state_t  state_r, state_nxt;
  logic        issued_r, pass_r;
  logic [1:0]  status_r;

  // datapath
  logic signed [12:0] x_r, y_r, zt_r;
  logic signed [51:0] prod_r;
  logic signed [47:0] acc_r, d2_r, num_r;
  logic [20:0]        c45_r;
  logic [21:0]        pd_r;
  logic [22:0]        dist_r;
  logic [24:0]        s_r;
  logic signed [25:0] c_r;
  logic signed [23:0] tx_r, ty_r;
  logic [23:0]        l1sq_r, l2sq_r;
  logic [25:0]        reach2_r;
  logic [36:0]        den_r;
  logic signed [35:0] base_r, theta_r, t1_r, t2_r;

  // held pose and output register
  logic signed [15:0] held_base_r, held_sh_r, held_el_r, held_wr_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic [1:0]         out_user_r;

  // shared unit
  aik_req_t           u_req;
  aik_rsp_t           u_rsp;
  logic signed [63:0] u_a, u_b, u_c, u_res_b;
  logic signed [35:0] u_res_z;

  // combinational helpers
  logic signed [25:0] ma, mb;
  logic               mul_en, in_acc, out_load, fail;
  logic signed [21:0] wx, wz;
  logic signed [35:0] pitch;
  logic [12:0]        reach;
  logic [11:0]        rmin;
  logic signed [24:0] sqdiff;
  logic [47:0]        mag;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign reach = {1'b0, l1_r} + {1'b0, l2_r};
  assign rmin  = (l1_r > l2_r) ? (l1_r - l2_r) : (l2_r - l1_r);

  // wrist offset in Q8 and pitch in Q30
  always_comb begin
    case (wrist_mode_r)
      WM_UP90: begin
        wx = '0; wz = 22'({l3_r, 8'd0}); pitch = HALF_PI_W;
      end
      WM_UP45: begin
        wx = 22'(c45_r); wz = 22'(c45_r); pitch = QUARTER_PI_W;
      end
      WM_DOWN45: begin
        wx = 22'(c45_r); wz = -22'(c45_r); pitch = -QUARTER_PI_W;
      end
      WM_DOWN90: begin
        wx = '0; wz = -22'({l3_r, 8'd0}); pitch = -HALF_PI_W;
      end
      default: begin
        wx = 22'({l3_r, 8'd0}); wz = '0; pitch = '0;
      end
    endcase
  end

  // reach test on the squared link-plane distance
  assign fail = (l1_r == 12'd0) || (l2_r == 12'd0) || (d2_r == 48'sd0) ||
                (d2_r > $signed({6'd0, reach2_r, 16'd0})) ||
                (d2_r < ($signed({8'd0, prod_r[23:0], 16'd0}) - 48'sd65536));

  assign sqdiff = pass_r ? ($signed({1'b0, l2sq_r}) - $signed({1'b0, l1sq_r}))
                         : ($signed({1'b0, l1sq_r}) - $signed({1'b0, l2sq_r}));
  assign mag    = num_r[47] ? 48'(-num_r) : 48'(num_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = in_tdata[38] ? ST_DONE : ST_MXX;
      ST_MXX:   state_nxt = ST_MYY;
      ST_MYY:   state_nxt = ST_MC45;
      ST_MC45:  state_nxt = ST_PD;
      ST_PD:    if (u_rsp.done) state_nxt = ST_BASE;
      ST_BASE:  if (u_rsp.done) state_nxt = ST_TXY;
      ST_TXY:   state_nxt = ST_MTX;
      ST_MTX:   state_nxt = ST_MTY;
      ST_MTY:   state_nxt = ST_ML1;
      ST_ML1:   state_nxt = ST_ML2;
      ST_ML2:   state_nxt = ST_MRE;
      ST_MRE:   state_nxt = ST_MRM;
      ST_MRM:   state_nxt = ST_CHK;
      ST_CHK:   state_nxt = fail ? ST_DONE : ST_DIST;
      ST_DIST:  if (u_rsp.done) state_nxt = ST_THETA;
      ST_THETA: if (u_rsp.done) state_nxt = ST_MDEN;
      ST_MDEN:  state_nxt = ST_ASET;
      ST_ASET:  state_nxt = ST_ACHK;
      ST_ACHK:  state_nxt = (mag >= 48'({den_r, 8'd0})) ? ST_ASGN : ST_ADIV;
      ST_ADIV:  if (u_rsp.done) state_nxt = ST_ASGN;
      ST_ASGN:  state_nxt = ST_AMUL;
      ST_AMUL:  state_nxt = ST_ASQ;
      ST_ASQ:   if (u_rsp.done) state_nxt = ST_AVEC;
      ST_AVEC:  if (u_rsp.done) state_nxt = pass_r ? ST_FIN : ST_MDEN;
      ST_FIN:   state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: unit requests, operands, multiplier inputs
  always_comb begin
    u_req.start = 1'b0;
    u_req.op    = OP_VEC;
    u_a         = '0;
    u_b         = '0;
    u_c         = '0;
    ma          = '0;
    mb          = '0;
    mul_en      = 1'b0;
    unique case (state_r)
      ST_MXX:  begin mul_en = 1'b1; ma = 26'(x_r); mb = 26'(x_r); end
      ST_MYY:  begin mul_en = 1'b1; ma = 26'(y_r); mb = 26'(y_r); end
      ST_MC45: begin mul_en = 1'b1; ma = 26'(l3_r); mb = 26'(COS45_Q16); end
      ST_MTX:  begin mul_en = 1'b1; ma = 26'(tx_r); mb = 26'(tx_r); end
      ST_MTY:  begin mul_en = 1'b1; ma = 26'(ty_r); mb = 26'(ty_r); end
      ST_ML1:  begin mul_en = 1'b1; ma = 26'(l1_r); mb = 26'(l1_r); end
      ST_ML2:  begin mul_en = 1'b1; ma = 26'(l2_r); mb = 26'(l2_r); end
      ST_MRE:  begin mul_en = 1'b1; ma = 26'(reach); mb = 26'(reach); end
      ST_MRM:  begin mul_en = 1'b1; ma = 26'(rmin); mb = 26'(rmin); end
      ST_MDEN: begin
        mul_en = 1'b1;
        ma     = pass_r ? 26'(l2_r) : 26'(l1_r);
        mb     = 26'(dist_r);
      end
      ST_AMUL: begin mul_en = 1'b1; ma = c_r; mb = c_r; end
      ST_PD: begin
        u_req.start = !issued_r;
        u_req.op    = OP_SQRT;
        u_a         = {acc_r, 16'd0};
      end
      ST_BASE: begin
        u_req.start = !issued_r;
        u_req.op    = OP_VEC;
        u_a         = {{35{y_r[12]}}, y_r, 16'd0};
        u_b         = {{35{x_r[12]}}, x_r, 16'd0};
      end
      ST_DIST: begin
        u_req.start = !issued_r;
        u_req.op    = OP_SQRT;
        u_a         = 64'(d2_r);
      end
      ST_THETA: begin
        u_req.start = !issued_r;
        u_req.op    = OP_VEC;
        u_a         = {{24{tx_r[23]}}, tx_r, 16'd0};
        u_b         = {{24{ty_r[23]}}, ty_r, 16'd0};
      end
      ST_ADIV: begin
        u_req.start = !issued_r;
        u_req.op    = OP_DIV;
        u_a         = {16'd0, mag};
        u_c         = {27'd0, den_r};
      end
      ST_ASQ: begin
        u_req.start = !issued_r;
        u_req.op    = OP_SQRT;
        u_a         = 64'sh1_0000_0000_0000 - 64'(prod_r);
      end
      ST_AVEC: begin
        u_req.start = !issued_r;
        u_req.op    = OP_VEC;
        u_a         = {{30{c_r[25]}}, c_r, 8'd0};
        u_b         = {31'd0, s_r, 8'd0};
      end
      default: begin
        u_req.start = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      issued_r      <= 1'b0;
      pass_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      base_height_r <= 12'd0;
      l1_r          <= 12'd100;
      l2_r          <= 12'd100;
      l3_r          <= 12'd50;
      wrist_mode_r  <= WM_LEVEL;
      held_base_r   <= '0;
      held_sh_r     <= '0;
      held_el_r     <= '0;
      held_wr_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (u_req.start)     issued_r <= 1'b1;
      else if (u_rsp.done) issued_r <= 1'b0;
      if (in_acc)
        pass_r <= 1'b0;
      else if (state_r == ST_AVEC && u_rsp.done)
        pass_r <= 1'b1;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BASE_HEIGHT: base_height_r <= cfg_data;
          REG_SHOULDER:    l1_r          <= cfg_data;
          REG_ELBOW:       l2_r          <= cfg_data;
          REG_WRIST:       l3_r          <= cfg_data;
          REG_WRIST_MODE:  wrist_mode_r  <= cfg_data[2:0];
          default:         ;
        endcase
      end
      if (state_r == ST_FIN) begin
        held_base_r <= to_out(base_r);
        held_sh_r   <= to_out(theta_r + t1_r - HALF_PI_W);
        held_el_r   <= to_out(-t1_r - t2_r);
        held_wr_r   <= to_out(pitch - theta_r + t2_r);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= ma * mb;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_r      <= in_tdata[12:0];
          y_r      <= in_tdata[25:13];
          zt_r     <= in_tdata[38:26];
          status_r <= STAT_FLOOR;
        end
      end
      ST_MYY:  acc_r <= 48'(prod_r);
      ST_MC45: acc_r <= acc_r + 48'(prod_r);
      ST_PD: begin
        if (!issued_r)  c45_r <= 21'((prod_r + 52'sd128) >>> 8);
        if (u_rsp.done) pd_r  <= u_res_b[21:0];
      end
      ST_BASE: if (u_rsp.done) base_r <= u_res_z;
      ST_TXY: begin
        tx_r <= $signed({2'd0, pd_r}) - 24'(wx);
        ty_r <= {{3{zt_r[12]}}, zt_r, 8'd0} - 24'(wz) - {4'd0, base_height_r, 8'd0};
      end
      ST_MTY:  acc_r    <= 48'(prod_r);
      ST_ML1:  d2_r     <= acc_r + 48'(prod_r);
      ST_ML2:  l1sq_r   <= prod_r[23:0];
      ST_MRE:  l2sq_r   <= prod_r[23:0];
      ST_MRM:  reach2_r <= prod_r[25:0];
      ST_CHK:  status_r <= fail ? STAT_REACH : STAT_SOLVED;
      ST_DIST: if (u_rsp.done) dist_r <= u_res_b[22:0];
      ST_THETA: if (u_rsp.done) theta_r <= u_res_z;
      ST_ASET: begin
        num_r <= d2_r + {{7{sqdiff[24]}}, sqdiff, 16'd0};
        den_r <= {prod_r[35:0], 1'b0};
      end
      ST_ACHK: c_r <= 26'sd16777216;
      ST_ADIV: if (u_rsp.done) c_r <= u_res_b[25:0];
      ST_ASGN: if (num_r[47]) c_r <= -c_r;
      ST_ASQ:  if (u_rsp.done) s_r <= u_res_b[24:0];
      ST_AVEC: begin
        if (u_rsp.done) begin
          if (pass_r) t2_r <= u_res_z;
          else        t1_r <= u_res_z;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {held_wr_r, held_el_r, held_sh_r, held_base_r};
      out_user_r <= status_r;
    end
  end

  aik_iter_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (u_req),
    .arg_a (u_a),
    .arg_b (u_b),
    .arg_c (u_c),
    .rsp   (u_rsp),
    .res_b (u_res_b),
    .res_z (u_res_z)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // the solver goes busy right after taking a target
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while solver busy");

  // the shared unit is never restarted mid-operation
  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    u_req.start |-> !u_rsp.busy)
    else $error("shared unit started while busy");

  // a result is only loaded from the final state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside final state");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_SOLVED || out_tuser == STAT_FLOOR ||
                    out_tuser == STAT_REACH))
    else $error("bad status code");

endmodule

// ===== sv/aik_iter_unit.sv =====
// ----------------------------------------------------------------------------
// aik_iter_unit: shared iterative arithmetic unit
// Vectoring CORDIC (atan2), floor square root and restoring divide, one step
// per cycle on a common set of wide registers.
// ----------------------------------------------------------------------------
module aik_iter_unit
  import aik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aik_req_t           req,
  input  logic signed [63:0] arg_a,
  input  logic signed [63:0] arg_b,
  input  logic signed [63:0] arg_c,
  output aik_rsp_t           rsp,
  output logic signed [63:0] res_b,
  output logic signed [35:0] res_z
);

  localparam int         NSTEP     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam logic [4:0] VEC_LAST  = 5'(NSTEP - 1);
  localparam logic [4:0] SQRT_LAST = 5'd25;
  localparam logic [4:0] DIV_LAST  = 5'd23;

  logic               busy_r, done_r, zero_r;
  aik_op_t            op_r;
  logic [4:0]         step_r;
  logic signed [63:0] a_r, b_r, c_r;
  logic signed [35:0] z_r;
  logic signed [63:0] a_nxt, b_nxt;
  logic signed [35:0] z_nxt;
  logic               last;
  logic signed [63:0] dx, dy, bitv, test, rem2;
  logic signed [35:0] ang;

  always_comb begin
    unique case (op_r)
      OP_VEC:  last = (step_r == VEC_LAST);
      OP_SQRT: last = (step_r == SQRT_LAST);
      default: last = (step_r == DIV_LAST);
    endcase
  end

  always_comb begin
    dx    = b_r >>> step_r;
    dy    = a_r >>> step_r;
    ang   = 36'(atan_lut(step_r));
    bitv  = 64'sd1 <<< (6'd50 - {step_r, 1'b0});
    test  = b_r + bitv;
    rem2  = {a_r[62:0], z_r[23]};
    a_nxt = a_r;
    b_nxt = b_r;
    z_nxt = z_r;
    case (op_r)
      OP_VEC: begin
        if (b_r >= 0) begin
          a_nxt = a_r + dx;
          b_nxt = b_r - dy;
          z_nxt = z_r + ang;
        end else begin
          a_nxt = a_r - dx;
          b_nxt = b_r + dy;
          z_nxt = z_r - ang;
        end
      end
      OP_SQRT: begin
        if (a_r >= test) begin
          a_nxt = a_r - test;
          b_nxt = (b_r >>> 1) + bitv;
        end else begin
          b_nxt = b_r >>> 1;
        end
      end
      default: begin
        // dividend low bits ride in z_r[23:0]
        z_nxt = {z_r[34:0], 1'b0};
        if (rem2 >= c_r) begin
          a_nxt = rem2 - c_r;
          b_nxt = {b_r[62:0], 1'b1};
        end else begin
          a_nxt = rem2;
          b_nxt = {b_r[62:0], 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_VEC;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        step_r <= '0;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.op)
        OP_VEC: begin
          zero_r <= (arg_a == 0) && (arg_b == 0);
          if (arg_a < 0) begin
            a_r <= -arg_a;
            b_r <= -arg_b;
            z_r <= (arg_b >= 0) ? PI_W : -PI_W;
          end else begin
            a_r <= arg_a;
            b_r <= arg_b;
            z_r <= '0;
          end
        end
        OP_SQRT: begin
          a_r <= arg_a;
          b_r <= '0;
        end
        default: begin
          a_r <= arg_a >>> 8;
          b_r <= '0;
          c_r <= arg_c;
          z_r <= {12'd0, arg_a[7:0], 16'd0};
        end
      endcase
    end else if (busy_r) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      z_r <= z_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res_b    = b_r;
  assign res_z    = zero_r ? 36'sd0 : z_r;

endmodule

// ===== tb/tb_arm_inverse_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// tb_arm_inverse_kinematics_core: self-checking testbench for the IK core
// Drives target points and register writes, predicts every pose with a
// bit-exact fixed point model kept in the bench, and compares each result
// transaction field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arm_inverse_kinematics_core;
  import aik_pkg::*;

  // one expected pose transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] base_ang;
    logic [15:0] shoulder_ang;
    logic [15:0] elbow_ang;
    logic [15:0] wrist_ang;
  } pose_t;

  localparam longint ONE_Q24 = 64'sd16777216;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;

  // bench copy of the registers and the held pose
  longint mdl_height, mdl_len1, mdl_len2, mdl_len3, mdl_mode;
  logic [15:0] hold_base, hold_shoulder, hold_elbow, hold_wrist;

  pose_t pending_poses[$];
  int    error_cnt   = 0;
  bit    quiet       = 1'b0;  // no idling on either side while set
  int    ready_stall = 0;

  arm_inverse_kinematics_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed point predictor
  // --------------------------------------------------------------------------
  function automatic longint atan_step(input int i);
    longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767, 16383, 8191,
                        4095, 2047, 1023, 511, 255, 127};
    return tab[i];
  endfunction

  // floor square root
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan2(y, x) with 30 fraction bits, 16 vectoring steps
  function automatic longint cordic_atan2(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      // pre-rotate by pi into the right half plane
      z = (y >= 0) ? longint'(PI_W) : -longint'(PI_W);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_step(i);
      end else begin
        x = x - dx; y = y + dy; z = z - atan_step(i);
      end
    end
    return z;
  endfunction

  // acos(num / den), num Q16, den Q8, cosine clamped to +-1
  function automatic longint law_acos(input longint num, input longint den);
    longint mag, c, s;
    mag = (num < 0) ? -num : num;
    if (mag >= den * 256) c = ONE_Q24;
    else c = (mag * 65536) / den;
    if (num < 0) c = -c;
    s = longint'(floor_sqrt(longint'(ONE_Q24 * ONE_Q24 - c * c)));
    return cordic_atan2(c * 256, s * 256);
  endfunction

  // round half up to Q4.12 and saturate
  function automatic logic [15:0] round_angle(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 17)) >>> 18;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic pose_t solve_pose(input longint x, input longint y, input longint z);
    longint base_w, pd, wx, wz, pitch, tx, ty, d2, reach, rmin, link_dist, theta, t1, t2;
    longint c45;
    pose_t  p;
    p.status = STAT_FLOOR;
    if (z >= 0) begin
      base_w = cordic_atan2(y * 65536, x * 65536);
      pd     = longint'(floor_sqrt(longint'(x * x + y * y) * 65536));
      c45    = (mdl_len3 * COS45_Q16 + 128) >>> 8;
      case (mdl_mode[2:0])
        WM_UP90:   begin wx = 0;   wz = mdl_len3 * 256;  pitch = HALF_PI_W; end
        WM_UP45:   begin wx = c45; wz = c45;             pitch = QUARTER_PI_W; end
        WM_DOWN45: begin wx = c45; wz = -c45;            pitch = -longint'(QUARTER_PI_W); end
        WM_DOWN90: begin wx = 0;   wz = -mdl_len3 * 256; pitch = -longint'(HALF_PI_W); end
        default:   begin wx = mdl_len3 * 256; wz = 0;    pitch = 0; end
      endcase
      tx    = pd - wx;
      ty    = z * 256 - wz - mdl_height * 256;
      d2    = tx * tx + ty * ty;
      reach = mdl_len1 + mdl_len2;
      rmin  = (mdl_len1 > mdl_len2) ? mdl_len1 - mdl_len2 : mdl_len2 - mdl_len1;
      if (mdl_len1 == 0 || mdl_len2 == 0 || d2 == 0 || d2 > reach * reach * 65536 ||
          d2 < rmin * rmin * 65536 - 65536) begin
        p.status = STAT_REACH;
      end else begin
        link_dist = longint'(floor_sqrt(d2));
        theta     = cordic_atan2(tx * 65536, ty * 65536);
        t1 = law_acos(d2 + (mdl_len1 * mdl_len1 - mdl_len2 * mdl_len2) * 65536,
                      2 * mdl_len1 * link_dist);
        t2 = law_acos(d2 + (mdl_len2 * mdl_len2 - mdl_len1 * mdl_len1) * 65536,
                      2 * mdl_len2 * link_dist);
        hold_base     = round_angle(base_w);
        hold_shoulder = round_angle(theta + t1 - HALF_PI_W);
        hold_elbow    = round_angle(-t1 - t2);
        hold_wrist    = round_angle(pitch - theta + t2);
        p.status      = STAT_SOLVED;
      end
    end
    // rejected targets answer the held pose
    p.base_ang     = hold_base;
    p.shoulder_ang = hold_shoulder;
    p.elbow_ang    = hold_elbow;
    p.wrist_ang    = hold_wrist;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, then compare against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int nxt;
    nxt = ready_stall;
    if (out_tvalid && out_tready) nxt = quiet ? 0 : $urandom_range(14);
    else if (nxt > 0) nxt = nxt - 1;
    ready_stall <= nxt;
    out_tready  <= rst_n && (nxt == 0);
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_poses.size() == 0) begin
        $error("result transaction with no prediction waiting");
        error_cnt++;
      end else begin
        want = pending_poses.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_cnt++;
        end
        if (out_tdata[15:0] !== want.base_ang) begin
          $error("base_angle: expected %0d, got %0d",
                 $signed(want.base_ang), $signed(out_tdata[15:0]));
          error_cnt++;
        end
        if (out_tdata[31:16] !== want.shoulder_ang) begin
          $error("shoulder_angle: expected %0d, got %0d",
                 $signed(want.shoulder_ang), $signed(out_tdata[31:16]));
          error_cnt++;
        end
        if (out_tdata[47:32] !== want.elbow_ang) begin
          $error("elbow_angle: expected %0d, got %0d",
                 $signed(want.elbow_ang), $signed(out_tdata[47:32]));
          error_cnt++;
        end
        if (out_tdata[63:48] !== want.wrist_ang) begin
          $error("wrist_angle: expected %0d, got %0d",
                 $signed(want.wrist_ang), $signed(out_tdata[63:48]));
          error_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------
  // one target transaction; prediction is made at the accepting edge
  task automatic send_target(input int x, input int y, input int z);
    int gap;
    logic [12:0] xs, ys, zs;
    gap = quiet ? 0 : $urandom_range(14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    xs = x[12:0];
    ys = y[12:0];
    zs = z[12:0];
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, zs, ys, xs};
    do @(posedge clk); while (!in_tready);
    pending_poses.push_back(solve_pose($signed(xs), $signed(ys), $signed(zs)));
  endtask

  // wait until every predicted result has been checked
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only issued while the core is idle
  task automatic write_reg(input logic [2:0] idx, input int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[11:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASE_HEIGHT: mdl_height = value & 12'hFFF;
      REG_SHOULDER:    mdl_len1   = value & 12'hFFF;
      REG_ELBOW:       mdl_len2   = value & 12'hFFF;
      REG_WRIST:       mdl_len3   = value & 12'hFFF;
      REG_WRIST_MODE:  mdl_mode   = value & 7;
      default: ;
    endcase
  endtask

  task automatic set_arm(input int h, input int l1, input int l2, input int l3, input int m);
    write_reg(REG_BASE_HEIGHT, h);
    write_reg(REG_SHOULDER, l1);
    write_reg(REG_ELBOW, l2);
    write_reg(REG_WRIST, l3);
    write_reg(REG_WRIST_MODE, m);
  endtask

  function automatic int clip13(input int v);
    return (v > 4095) ? 4095 : ((v < -4096) ? -4096 : v);
  endfunction

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset values, coordinate extremes and the floor case
  task automatic test_defaults();
    send_target(0, 0, 0);
    send_target(100, 0, 50);
    send_target(0, 100, 0);
    send_target(-4096, -4096, 4095);
    send_target(4095, 4095, 4095);
    send_target(0, 0, -1);
    send_target(-4096, 0, -4096);
    send_target(0, -100, 30);
    send_target(-100, -5, 20);
    send_target(70, 70, 60);
  endtask

  // point exactly at the shoulder, inner reach limit, zero length link
  task automatic test_reach_limits();
    set_arm(0, 100, 100, 50, WM_UP90);
    send_target(0, 0, 50);
    send_target(90, 40, 120);
    set_arm(0, 150, 50, 50, WM_LEVEL);
    send_target(60, 0, 0);
    send_target(150, 0, 0);
    set_arm(0, 0, 100, 50, WM_LEVEL);
    send_target(100, 0, 0);
    set_arm(4095, 4095, 4095, 4095, WM_LEVEL);
    send_target(4095, -4096, 4095);
    send_target(-4096, 4095, 0);
    set_arm(0, 1, 1, 1, WM_LEVEL);
    send_target(2, 0, 0);
    send_target(3, 1, 1);
  endtask

  // every wrist pitch including the unused codes
  task automatic test_wrist_modes();
    for (int m = 0; m < 8; m++) begin
      set_arm(20, 120, 90, 40, m);
      send_target(120, 30, 80);
      send_target(-60, 90, 10);
    end
  endtask

  // random arms with mostly reachable targets, some below floor or far off
  task automatic test_random(input int phases, input int per_phase);
    int h, l1, l2, l3, span, x, y, z, kind;
    for (int ph = 0; ph < phases; ph++) begin
      quiet = (ph % 4 == 3);
      h  = ($urandom_range(4) == 0) ? pick(0, 4095) : pick(0, 300);
      l1 = ($urandom_range(4) == 0) ? pick(1, 4095) : pick(1, 400);
      l2 = ($urandom_range(4) == 0) ? pick(1, 4095) : pick(1, 400);
      l3 = ($urandom_range(4) == 0) ? pick(1, 4095) : pick(1, 200);
      set_arm(h, l1, l2, l3, $urandom_range(7));
      span = l1 + l2 + l3 + 10;
      for (int n = 0; n < per_phase; n++) begin
        kind = $urandom_range(9);
        if (kind < 7) begin
          x = clip13(pick(-span, span));
          y = clip13(pick(-span, span));
          z = clip13(h + pick(-span, span));
        end else if (kind == 7) begin
          x = pick(-4096, 4095);
          y = pick(-4096, 4095);
          z = pick(-4096, -1);
        end else begin
          x = pick(-4096, 4095);
          y = pick(-4096, 4095);
          z = pick(-4096, 4095);
        end
        send_target(x, y, z);
        // hold off once mid-phase until the core has answered everything
        if (ph == 2 && n == per_phase / 2) drain_results();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    mdl_height = 0; mdl_len1 = 100; mdl_len2 = 100; mdl_len3 = 50; mdl_mode = WM_LEVEL;
    hold_base = '0; hold_shoulder = '0; hold_elbow = '0; hold_wrist = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_defaults();
    test_reach_limits();
    test_wrist_modes();
    test_random(12, 68);

    drain_results();
    repeat (300) @(posedge clk);
    if (error_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // run limit: the full serialized solve per target plus worst idling, many times over
  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
